// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int SCREEN_COLUMNS = 24;
   localparam int SCREEN_ROWS    = 12;
   localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;

   localparam int ROW_W  = 4;
   localparam int COL_W  = 5;
   localparam int ADDR_W = $clog2(CELL_COUNT);

   localparam int TAB_SPACES = 4;
   localparam int TAB_W      = $clog2(TAB_SPACES);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] PRINT_LOW  = 8'd32;
   localparam logic [7:0] PRINT_HIGH = 8'd126;
   localparam logic [6:0] GLYPH_DOT   = 7'h2E;
   localparam logic [6:0] GLYPH_SPACE = 7'h20;
   localparam logic [6:0] GLYPH_NONE  = 7'h00;

   localparam logic KIND_GLYPH = 1'b0;
   localparam logic KIND_BREAK = 1'b1;

   typedef logic [7:0]       char_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [COL_W-1:0] col_type;
   typedef logic [6:0]       glyph_type;

   typedef struct packed {
      logic      kind;
      row_type   row;
      col_type   col;
      glyph_type glyph;
      logic      scrolled;
      logic      last;
   } rsp_type;

endpackage

// ===== hw/rtl/text_console_char_writer.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Ports                                              Transfer
// req      in         req_valid, req_ready, req_char_in                  valid & ready
// rsp      out        rsp_valid, rsp_ready, rsp_event_kind, rsp_cell_row, valid & ready
//                     rsp_cell_column, rsp_glyph, rsp_scrolled, rsp_last
//
// One byte per cycle while req_ready is high; a tab holds req_ready low while
// its four space results are generated by the single cell-write port.
// Results leave through a two-entry output queue; tab results stall only while
// the queue holds two entries, and req_ready is also low then. rsp_valid is
// registered and rises in the cycle after a result is queued.
// Synchronous reset clears cursor, row base, row lengths and the queue;
// the cell memory is not cleared.

module text_console_char_writer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcw_pkg::char_type   req_char_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_kind,
   output tcw_pkg::row_type    rsp_cell_row,
   output tcw_pkg::col_type    rsp_cell_column,
   output tcw_pkg::glyph_type  rsp_glyph,
   output logic                rsp_scrolled,
   output logic                rsp_last
);
   import tcw_pkg::*;

   localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(SCREEN_COLUMNS);
   localparam row_type           ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
   localparam col_type           COL_FULL = COL_W'(SCREEN_COLUMNS);

   glyph_type  cell_mem [CELL_COUNT];
   col_type    row_len_ff [SCREEN_ROWS];

   row_type          cur_row_ff, cur_row_in;
   col_type          cur_col_ff, cur_col_in;
   row_type          base_ff, base_in;
   logic [TAB_W-1:0] tab_left_ff, tab_left_in;

   rsp_type    fifo_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   logic        gen_go, take_req, do_glyph, do_break, last;
   logic        wrap, at_bottom, scroll, push, pop;
   glyph_type   g;
   row_type     row_w, base_w;
   col_type     col_w;
   logic [ROW_W:0] phys_sum;
   row_type     phys;
   logic [ADDR_W-1:0] cell_addr;
   rsp_type     rsp_new;

   assign gen_go    = (count_ff != 2'd2);
   assign req_ready = gen_go && (tab_left_ff == '0);
   assign take_req  = req_valid && req_ready;

   always_comb begin
      do_glyph    = 1'b0;
      do_break    = 1'b0;
      g           = GLYPH_SPACE;
      last        = 1'b1;
      tab_left_in = tab_left_ff;
      if (gen_go && tab_left_ff != '0) begin
         do_glyph    = 1'b1;
         tab_left_in = tab_left_ff - 1'b1;
         last        = (tab_left_ff == TAB_W'(1));
      end else if (take_req) begin
         case (req_char_in)
            CHAR_CR: ;
            CHAR_LF: do_break = 1'b1;
            CHAR_TAB: begin
               do_glyph    = 1'b1;
               tab_left_in = TAB_W'(TAB_SPACES - 1);
               last        = 1'b0;
            end
            default: begin
               do_glyph = 1'b1;
               if (req_char_in inside {[PRINT_LOW:PRINT_HIGH]}) begin
                  g = req_char_in[6:0];
               end else begin
                  g = GLYPH_DOT;
               end
            end
         endcase
      end
   end

   always_comb begin
      wrap      = do_break || (do_glyph && cur_col_ff == COL_FULL);
      at_bottom = (cur_row_ff == ROW_LAST);
      scroll    = wrap && at_bottom;
      row_w     = (wrap && !at_bottom) ? cur_row_ff + 1'b1 : cur_row_ff;
      base_w    = scroll ? ((base_ff == ROW_LAST) ? '0 : base_ff + 1'b1) : base_ff;
      col_w     = wrap ? '0 : cur_col_ff;
      phys_sum  = {1'b0, base_w} + {1'b0, row_w};
      phys      = (phys_sum >= (ROW_W + 1)'(SCREEN_ROWS))
                  ? ROW_W'(phys_sum - (ROW_W + 1)'(SCREEN_ROWS)) : phys_sum[ROW_W-1:0];
      cell_addr = ADDR_W'(phys) * COLS_A + ADDR_W'(col_w);
      push      = do_glyph || do_break;

      cur_row_in = push ? row_w : cur_row_ff;
      base_in    = base_w;
      cur_col_in = do_glyph ? col_w + 1'b1 : (do_break ? '0 : cur_col_ff);

      rsp_new.kind     = do_break ? KIND_BREAK : KIND_GLYPH;
      rsp_new.row      = row_w;
      rsp_new.col      = col_w;
      rsp_new.glyph    = do_break ? GLYPH_NONE : g;
      rsp_new.scrolled = scroll;
      rsp_new.last     = last;
   end

   always_ff @(posedge clock) begin
      if (do_glyph) begin
         cell_mem[cell_addr] <= g;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCREEN_ROWS; i++) begin
            row_len_ff[i] <= '0;
         end
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         base_ff     <= '0;
         tab_left_ff <= '0;
      end else begin
         if (do_glyph) begin
            row_len_ff[phys] <= col_w + 1'b1;
         end else if (scroll) begin
            row_len_ff[base_ff] <= '0;
         end
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         base_ff     <= base_in;
         tab_left_ff <= tab_left_in;
      end
   end

   // output queue
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   assign rsp_event_kind  = fifo_ff[rd_ptr_ff].kind;
   assign rsp_cell_row    = fifo_ff[rd_ptr_ff].row;
   assign rsp_cell_column = fifo_ff[rd_ptr_ff].col;
   assign rsp_glyph       = fifo_ff[rd_ptr_ff].glyph;
   assign rsp_scrolled    = fifo_ff[rd_ptr_ff].scrolled;
   assign rsp_last        = fifo_ff[rd_ptr_ff].last;

endmodule
